### rtl/core/priority_round_robin_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent check helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PRRS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed");
// next-cycle implication
`define PRRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed");
`else
`define PRRS_ASSERT_NOW(label, ante, cons)
`define PRRS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/prrs_pkg.sv
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types, codes and helpers of the round-robin scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package prrs_pkg;

   localparam int TASK_SLOTS_DEFAULT = 16;
   localparam int ID_BITS_DEFAULT    = 16;

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_CREATE  = 3'd1;
   localparam logic [2:0] MODE_KILL    = 3'd2;
   localparam logic [2:0] MODE_BLOCK   = 3'd3;
   localparam logic [2:0] MODE_UNBLOCK = 3'd4;
   localparam logic [2:0] MODE_TOGGLE  = 3'd5;
   localparam logic [2:0] MODE_PRIO    = 3'd6;
   localparam logic [2:0] MODE_YIELD   = 3'd7;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_NOTFOUND = 3'd1;
   localparam logic [2:0] STAT_BADPRIO  = 3'd2;
   localparam logic [2:0] STAT_FULL     = 3'd3;
   localparam logic [2:0] STAT_IDLE     = 3'd4;

   localparam logic [1:0] CSR_QUANTUM  = 2'd0;
   localparam logic [1:0] CSR_LOWEST   = 2'd1;
   localparam logic [1:0] CSR_DEFPRIO  = 2'd2;

   localparam logic [7:0] QUANTUM_RESET = 8'd1;
   localparam logic [4:0] LOWEST_RESET  = 5'd19;
   localparam logic [4:0] DEFPRIO_RESET = 5'd0;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] task_id;
      logic [4:0]  new_priority;
      logic [63:0] stack_pointer;
   } op_type;

   typedef struct packed {
      logic [7:0] quantum;
      logic [4:0] lowest;
      logic [4:0] defprio;
   } cfg_type;

   // ticket reload: (lowest + 1 - prio) * quantum, zero past the lowest priority
   function automatic logic [12:0] reload_tickets(input logic [4:0] prio,
                                                  input logic [4:0] lowest,
                                                  input logic [7:0] quantum);
      logic [13:0] prod;
      prod = 14'({1'b0, lowest} + 6'd1 - {1'b0, prio}) * 14'(quantum);
      if (prio > lowest) return 13'd0;
      return prod[12:0];
   endfunction

endpackage

`default_nettype wire

### rtl/core/prrs_front.sv
// ----------------------------------------------------------------------------
// prrs_front
// Request intake: two-entry queue between the request port and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module prrs_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [87:0]          req_tdata,
   input  wire  [2:0]           req_tuser,
   output logic                 op_valid,
   input  wire                  op_ready,
   output prrs_pkg::op_type     op
);
   import prrs_pkg::*;

   op_type     q_ff [2];
   op_type     q_in [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_tready = (cnt_ff != 2'd2);
   assign op_valid   = (cnt_ff != 2'd0);
   assign op         = q_ff[rp_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = op_valid && op_ready;

   always_comb begin
      q_in  = q_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) begin
         q_in[wp_ff].mode          = req_tuser;
         q_in[wp_ff].task_id       = req_tdata[15:0];
         q_in[wp_ff].new_priority  = req_tdata[20:16];
         q_in[wp_ff].stack_pointer = req_tdata[84:21];
         wp_in = ~wp_ff;
      end
      if (pop) rp_in = ~rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/prrs_back.sv
// ----------------------------------------------------------------------------
// prrs_back
// Scheduling engine: slot table, ready and blocked orders, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prrs_back #(
   parameter int TASK_SLOTS = prrs_pkg::TASK_SLOTS_DEFAULT,
   parameter int ID_BITS    = prrs_pkg::ID_BITS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  prrs_pkg::cfg_type    cfg,
   input  wire                  op_valid,
   output logic                 op_ready,
   input  prrs_pkg::op_type     op,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [95:0]          rsp_tdata,
   output logic [3:0]           rsp_tuser
);
   import prrs_pkg::*;

   localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = SW + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TICK  = 3'd1;
   localparam logic [2:0] ST_FREE  = 3'd2;
   localparam logic [2:0] ST_FINDR = 3'd3;
   localparam logic [2:0] ST_FINDB = 3'd4;
   localparam logic [2:0] ST_SHR   = 3'd5;
   localparam logic [2:0] ST_SHB   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]         st_ff, st_in;
   logic               used_ff [TASK_SLOTS];
   logic               used_in [TASK_SLOTS];
   logic [ID_BITS-1:0] sid_ff [TASK_SLOTS];
   logic [ID_BITS-1:0] sid_in [TASK_SLOTS];
   logic [4:0]         prio_ff [TASK_SLOTS];
   logic [4:0]         prio_in [TASK_SLOTS];
   logic [12:0]        tick_ff [TASK_SLOTS];
   logic [12:0]        tick_in [TASK_SLOTS];
   logic [63:0]        ssp_ff [TASK_SLOTS];
   logic [63:0]        ssp_in [TASK_SLOTS];
   logic [SW-1:0]      rord_ff [TASK_SLOTS];
   logic [SW-1:0]      rord_in [TASK_SLOTS];
   logic [SW-1:0]      bord_ff [TASK_SLOTS];
   logic [SW-1:0]      bord_in [TASK_SLOTS];
   logic [CW-1:0]      rcnt_ff, rcnt_in, bcnt_ff, bcnt_in;
   logic [SW-1:0]      rcur_ff, rcur_in;
   logic               runv_ff, runv_in;
   logic [SW-1:0]      runs_ff, runs_in;
   logic [ID_BITS-1:0] nid_ff, nid_in;

   // operation in flight
   logic [2:0]         mode_ff, mode_in;
   logic [ID_BITS-1:0] tid_ff, tid_in;
   logic [4:0]         np_ff, np_in;
   logic [63:0]        osp_ff, osp_in;
   logic [CW-1:0]      idx_ff, idx_in, pos_ff, pos_in;
   logic [SW-1:0]      s_ff, s_in;
   logic [2:0]         stat_ff, stat_in;
   logic [63:0]        res_ff, res_in;
   logic [15:0]        crt_ff, crt_in;
   logic               rsch_ff, rsch_in;

   logic               ov_ff, ov_in;
   logic [95:0]        od_ff, od_in;
   logic [3:0]         ou_ff, ou_in;

   logic [SW-1:0]      nxt_slot, rc_dec;
   logic [CW-1:0]      idx_p1;
   logic [ID_BITS-1:0] nid_p1;

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;
   assign nxt_slot   = rord_ff[rcur_ff];
   assign idx_p1     = idx_ff + CW'(1);
   assign nid_p1     = nid_ff + ID_BITS'(1);
   assign rc_dec     = (pos_ff < CW'(rcur_ff)) ? rcur_ff - SW'(1) : rcur_ff;

   always_comb begin
      st_in = st_ff;     used_in = used_ff; sid_in = sid_ff;   prio_in = prio_ff;
      tick_in = tick_ff; ssp_in = ssp_ff;   rord_in = rord_ff; bord_in = bord_ff;
      rcnt_in = rcnt_ff; bcnt_in = bcnt_ff; rcur_in = rcur_ff; runv_in = runv_ff;
      runs_in = runs_ff; nid_in = nid_ff;   mode_in = mode_ff; tid_in = tid_ff;
      np_in = np_ff;     osp_in = osp_ff;   idx_in = idx_ff;   pos_in = pos_ff;
      s_in = s_ff;       stat_in = stat_ff; res_in = res_ff;   crt_in = crt_ff;
      rsch_in = rsch_ff; ov_in = ov_ff;     od_in = od_ff;     ou_in = ou_ff;
      op_ready = 1'b0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (op_valid) begin
               op_ready = 1'b1;
               mode_in  = op.mode;
               tid_in   = ID_BITS'(op.task_id);
               np_in    = op.new_priority;
               osp_in   = op.stack_pointer;
               idx_in   = '0;
               stat_in  = STAT_OK;
               res_in   = '0;
               crt_in   = '0;
               rsch_in  = 1'b0;
               case (op.mode)
                  MODE_TICK:    st_in = ST_TICK;
                  MODE_YIELD: begin
                     if (runv_ff) tick_in[runs_ff] = '0;
                     st_in = ST_TICK;
                  end
                  MODE_CREATE:  st_in = ST_FREE;
                  MODE_UNBLOCK: st_in = ST_FINDB;
                  MODE_PRIO: begin
                     if (op.new_priority > cfg.lowest) begin
                        stat_in = STAT_BADPRIO;
                        st_in   = ST_DONE;
                     end else if (runv_ff && ID_BITS'(op.task_id) != '0 &&
                                  sid_ff[runs_ff] == ID_BITS'(op.task_id)) begin
                        prio_in[runs_ff] = op.new_priority;
                        st_in = ST_DONE;
                     end else begin
                        st_in = ST_FINDR;
                     end
                  end
                  default:      st_in = ST_FINDR;
               endcase
            end
         end
         ST_TICK: begin
            st_in = ST_DONE;
            if (rcnt_ff == '0) begin
               runv_in = 1'b0;
               res_in  = osp_ff;
               stat_in = STAT_IDLE;
            end else if (!runv_ff) begin
               runs_in = nxt_slot;
               runv_in = 1'b1;
               res_in  = ssp_ff[nxt_slot];
               rcur_in = (CW'(rcur_ff) + CW'(1) == rcnt_ff) ? '0 : rcur_ff + SW'(1);
            end else begin
               ssp_in[runs_ff] = osp_ff;
               if (tick_ff[runs_ff] != '0) begin
                  tick_in[runs_ff] = tick_ff[runs_ff] - 13'd1;
                  res_in = osp_ff;
               end else begin
                  tick_in[runs_ff] = reload_tickets(prio_ff[runs_ff], cfg.lowest,
                                                    cfg.quantum);
                  runs_in = nxt_slot;
                  res_in  = (nxt_slot == runs_ff) ? osp_ff : ssp_ff[nxt_slot];
                  rcur_in = (CW'(rcur_ff) + CW'(1) == rcnt_ff) ? '0 : rcur_ff + SW'(1);
               end
            end
         end
         ST_FREE: begin
            if (idx_ff == CW'(TASK_SLOTS)) begin
               stat_in = STAT_FULL;
               st_in   = ST_DONE;
            end else if (!used_ff[idx_ff[SW-1:0]]) begin
               used_in[idx_ff[SW-1:0]] = 1'b1;
               sid_in[idx_ff[SW-1:0]]  = nid_ff;
               prio_in[idx_ff[SW-1:0]] = cfg.defprio;
               tick_in[idx_ff[SW-1:0]] = reload_tickets(cfg.defprio, cfg.lowest,
                                                        cfg.quantum);
               ssp_in[idx_ff[SW-1:0]]  = osp_ff;
               crt_in = 16'(nid_ff);
               nid_in = (nid_p1 == '0) ? ID_BITS'(1) : nid_p1;
               if (rcnt_ff == '0) rcur_in = '0;
               rord_in[rcnt_ff[SW-1:0]] = idx_ff[SW-1:0];
               rcnt_in = rcnt_ff + CW'(1);
               st_in   = ST_DONE;
            end else begin
               idx_in = idx_p1;
            end
         end
         ST_FINDR: begin
            if (tid_ff == '0 || idx_ff >= rcnt_ff) begin
               if (mode_ff == MODE_BLOCK) begin
                  stat_in = STAT_NOTFOUND;
                  st_in   = ST_DONE;
               end else begin
                  idx_in = '0;
                  st_in  = ST_FINDB;
               end
            end else if (sid_ff[rord_ff[idx_ff[SW-1:0]]] == tid_ff) begin
               s_in   = rord_ff[idx_ff[SW-1:0]];
               pos_in = idx_ff;
               if (mode_ff == MODE_PRIO) begin
                  prio_in[rord_ff[idx_ff[SW-1:0]]] = np_ff;
                  st_in = ST_DONE;
               end else begin
                  st_in = ST_SHR;
               end
            end else begin
               idx_in = idx_p1;
            end
         end
         ST_FINDB: begin
            if (tid_ff == '0 || idx_ff >= bcnt_ff) begin
               stat_in = STAT_NOTFOUND;
               st_in   = ST_DONE;
            end else if (sid_ff[bord_ff[idx_ff[SW-1:0]]] == tid_ff) begin
               s_in   = bord_ff[idx_ff[SW-1:0]];
               pos_in = idx_ff;
               if (mode_ff == MODE_PRIO) begin
                  prio_in[bord_ff[idx_ff[SW-1:0]]] = np_ff;
                  st_in = ST_DONE;
               end else begin
                  st_in = ST_SHB;
               end
            end else begin
               idx_in = idx_p1;
            end
         end
         ST_SHR: begin
            if (idx_p1 < rcnt_ff) begin
               rord_in[idx_ff[SW-1:0]] = rord_ff[idx_p1[SW-1:0]];
               idx_in = idx_p1;
            end else begin
               rcnt_in = rcnt_ff - CW'(1);
               rcur_in = (CW'(rc_dec) >= rcnt_ff - CW'(1)) ? '0 : rc_dec;
               if (mode_ff == MODE_KILL) begin
                  used_in[s_ff] = 1'b0;
               end else begin
                  bord_in[bcnt_ff[SW-1:0]] = s_ff;
                  bcnt_in = bcnt_ff + CW'(1);
               end
               if (runv_ff && runs_ff == s_ff) begin
                  runv_in = 1'b0;
                  rsch_in = 1'b1;
               end
               st_in = ST_DONE;
            end
         end
         ST_SHB: begin
            if (idx_p1 < bcnt_ff) begin
               bord_in[idx_ff[SW-1:0]] = bord_ff[idx_p1[SW-1:0]];
               idx_in = idx_p1;
            end else begin
               bcnt_in = bcnt_ff - CW'(1);
               if (mode_ff == MODE_KILL) begin
                  used_in[s_ff] = 1'b0;
                  if (runv_ff && runs_ff == s_ff) begin
                     runv_in = 1'b0;
                     rsch_in = 1'b1;
                  end
               end else begin
                  if (rcnt_ff == '0) rcur_in = '0;
                  rord_in[rcnt_ff[SW-1:0]] = s_ff;
                  rcnt_in = rcnt_ff + CW'(1);
               end
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               od_in = {crt_ff, (runv_ff ? 16'(sid_ff[runs_ff]) : 16'd0), res_ff};
               ou_in = {rsch_ff, stat_ff};
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sid_ff <= sid_in;   prio_ff <= prio_in; tick_ff <= tick_in; ssp_ff <= ssp_in;
      rord_ff <= rord_in; bord_ff <= bord_in; mode_ff <= mode_in; tid_ff <= tid_in;
      np_ff <= np_in;     osp_ff <= osp_in;   idx_ff <= idx_in;   pos_ff <= pos_in;
      s_ff <= s_in;       stat_ff <= stat_in; res_ff <= res_in;   crt_ff <= crt_in;
      rsch_ff <= rsch_in; od_ff <= od_in;     ou_ff <= ou_in;
      if (reset) begin
         st_ff   <= ST_IDLE;
         used_ff <= '{default: 1'b0};
         rcnt_ff <= '0;
         bcnt_ff <= '0;
         rcur_ff <= '0;
         runv_ff <= 1'b0;
         runs_ff <= '0;
         nid_ff  <= ID_BITS'(1);
         ov_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         used_ff <= used_in;
         rcnt_ff <= rcnt_in;
         bcnt_ff <= bcnt_in;
         rcur_ff <= rcur_in;
         runv_ff <= runv_in;
         runs_ff <= runs_in;
         nid_ff  <= nid_in;
         ov_ff   <= ov_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/priority_round_robin_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_unit
// Task-slot scheduler with a rotating ready order and a blocked order.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one scheduler event per transfer (tick, create, kill, block,
//    unblock, toggle, set priority, yield); rsp_* returns exactly one result
//    per event, in order. csr_* writes the three configuration registers and
//    is always ready; write it only while the block is idle.
//  - Per event, from acceptance to result: tick and yield go through the tick
//    state; create scans the slot table for a free slot; kill, block, unblock,
//    toggle and set priority search the ready list, the blocked list or both,
//    one entry per cycle, and all but set priority then compact that list from
//    the match to the list end; together they visit each listed slot about once.
//    The sequential search and shift loop in the engine sets the rate.
//  - A two-entry request queue keeps taking transfers while the engine works,
//    and a result register lets the engine move on while a result waits.
//  - Reset (synchronous, active high) empties the slot table and both lists,
//    sets the next id to one and restores the register defaults. No clearing
//    pass is needed; tables are read only through listed slots.
//  - When the receiver stalls, the result holds, the engine waits after
//    finishing its next event and the request queue fills, then drops
//    req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_round_robin_scheduler_unit_defines.svh"

module priority_round_robin_scheduler_unit #(
   parameter int TASK_SLOTS = prrs_pkg::TASK_SLOTS_DEFAULT,
   parameter int ID_BITS    = prrs_pkg::ID_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [87:0] req_tdata,   // task_id[15:0], new_priority[20:16],
                                    // stack_pointer[84:21], zero pad
   input  wire  [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,   // resume_pointer[63:0], running_id[79:64],
                                    // created_id[95:80]
   output logic [3:0]  rsp_tuser,   // status[2:0], reschedule[3]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [7:0]  csr_data
);
   import prrs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   op_type  op;
   logic    op_valid, op_ready;

   assign csr_ready = 1'b1;

   // register writes; an index past the list is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_QUANTUM: cfg_in.quantum = csr_data;
            CSR_LOWEST:  cfg_in.lowest  = csr_data[4:0];
            CSR_DEFPRIO: cfg_in.defprio = csr_data[4:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quantum <= QUANTUM_RESET;
         cfg_ff.lowest  <= LOWEST_RESET;
         cfg_ff.defprio <= DEFPRIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: intake queue
   prrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op         (op)
   );

   // back: scheduling engine and result register
   prrs_back #(
      .TASK_SLOTS (TASK_SLOTS),
      .ID_BITS    (ID_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op         (op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // idle means nothing runs
   `PRRS_ASSERT_NOW(a_idle_no_run, rsp_tvalid && rsp_tuser[2:0] == STAT_IDLE,
                    rsp_tdata[79:64] == 16'd0)
   // a new id comes only with a good status
   `PRRS_ASSERT_NOW(a_create_ok, rsp_tvalid && rsp_tdata[95:80] != 16'd0,
                    rsp_tuser[2:0] == STAT_OK)
   // reschedule only on a successful removal, and the task no longer runs
   `PRRS_ASSERT_NOW(a_resched_ok, rsp_tvalid && rsp_tuser[3],
                    rsp_tuser[2:0] == STAT_OK && rsp_tdata[79:64] == 16'd0)
   // engine takes a queued op only after its previous result is registered
   `PRRS_ASSERT_NEXT(a_one_in_flight, op_valid && op_ready, !op_ready)

endmodule

`default_nettype wire
